@@ hw/rtl/bfha_pkg.sv @@
// Shared codes and widths for the best-fit heap allocator.
package bfha_pkg;

    // Operation codes
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO     = 2'd1;
    localparam logic [1:0] ST_NO_FIT   = 2'd2;
    localparam logic [1:0] ST_BAD_ADDR = 2'd3;

    // Configuration register indexes
    localparam logic CFG_HEAP_BASE = 1'b0;
    localparam logic CFG_HEAP_SIZE = 1'b1;

    localparam int CFG_DATA_BITS = 32;
    localparam int SIZE_BITS     = 24;
    localparam int ADDR_BITS     = 32;

endpackage

@@ hw/rtl/bfha_req_if.sv @@
// Request and response channel interfaces.
interface bfha_req_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [23:0] request_size;
    logic [31:0] address;

    modport source (output valid, func, request_size, address, input ready);
    modport sink   (input valid, func, request_size, address, output ready);
endinterface

interface bfha_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] result_address;
    logic [23:0] free_space;

    modport source (output valid, status, result_address, free_space, input ready);
    modport sink   (input valid, status, result_address, free_space, output ready);
endinterface

@@ hw/rtl/bfha_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
module bfha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ hw/rtl/best_fit_heap_allocator.sv @@
// Best-fit heap allocator: a sequenced table of blocks kept in one RAM.
// Each operation runs through a controller that walks the table one entry per
// cycle through a RAM with one write port and one registered read port. An
// allocation scans all N table entries, then, on a split, moves the entries
// above the chosen one up by one, each move being a read state then a write
// state. A free scans until the hit, then merges, moving entries down by one or
// two places the same way. A configuration write rebuilds the table (three
// entries, or none if the heap is under two headers), during which no request
// is taken. One request is in work at a time; the result sits in an output
// register and the next request is held off until that result beat has been
// taken.
module best_fit_heap_allocator
    import bfha_pkg::*;
#(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 16,
    parameter int WORD_BYTES   = 8,
    parameter int OFFSET_BITS  = 24
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic                     cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    bfha_req_if.sink                 req,
    bfha_rsp_if.source               rsp
);
    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int EW = 2 * OFFSET_BITS + 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_INIT  = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_DEC   = 4'd3;
    localparam logic [3:0] S_MVRD  = 4'd4;
    localparam logic [3:0] S_MVWR  = 4'd5;
    localparam logic [3:0] S_SPLIT = 4'd6;
    localparam logic [3:0] S_NBRD  = 4'd7;
    localparam logic [3:0] S_NBCHK = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;
    localparam logic [3:0] S_PVCHK = 4'd10;

    typedef struct packed {
        logic [OFFSET_BITS-1:0] off;
        logic [OFFSET_BITS-1:0] len;
        logic                   free;
    } entry_t;

    // Table memory
    logic          we;
    logic [IW-1:0] waddr, raddr;
    entry_t        wdata, rdata;

    bfha_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCKS)) u_table (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    logic [3:0]             state_reg;
    logic [31:0]            base_reg;
    logic [23:0]            size_reg;
    logic [CW-1:0]          count_reg;
    logic [23:0]            fcnt_reg;
    logic                   func_reg;
    logic [OFFSET_BITS:0]   total_reg;
    logic [32:0]            rel_reg;
    logic [CW-1:0]          idx_reg;     // scan/read index
    logic                   found_reg;
    logic [IW-1:0]          best_reg;
    entry_t                 best_ent_reg;
    entry_t                 hold_reg;    // entry being merged / updated
    logic [CW-1:0]          mv_reg;      // move cursor
    logic [CW-1:0]          mv_end_reg;
    logic [1:0]             gap_reg;     // move distance down (free); unused for up
    logic                   up_reg;
    logic                   prev_free_reg;
    entry_t                 prev_reg;
    logic [1:0]             initc_reg;
    logic                   rsp_valid_reg;
    logic [1:0]             st_reg;
    logic [31:0]            ra_reg;
    logic                   rd_v_reg;    // read issued last cycle

    // Request decode
    logic [24:0]            aligned;
    logic [OFFSET_BITS+1:0] total_calc;
    assign aligned    = (25'(req.request_size) + 25'(WORD_BYTES - 1)) &
                        ~25'(WORD_BYTES - 1) ;
    assign total_calc = (OFFSET_BITS+2)'(aligned) + (OFFSET_BITS+2)'(HEADER_BYTES);

    logic       take;
    assign req.ready = (state_reg == S_IDLE) && !rsp_valid_reg && !cfg_we;
    assign take      = req.valid && req.ready;

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.status         = st_reg;
    assign rsp.result_address = ra_reg;
    assign rsp.free_space     = fcnt_reg;

    // Scan compares on the entry returned by the RAM
    logic fit, better, hit_c;
    logic [OFFSET_BITS:0] lo_c, hi_c;
    assign fit    = rdata.free && ({1'b0, rdata.len} >= total_reg);
    assign better = !found_reg || (rdata.len < best_ent_reg.len);
    assign lo_c   = {1'b0, rdata.off} + (OFFSET_BITS+1)'(HEADER_BYTES);
    assign hi_c   = {1'b0, rdata.off} + {1'b0, rdata.len};
    assign hit_c  = !rdata.free && (rel_reg >= 33'(lo_c)) && (rel_reg < 33'(hi_c));

    logic split_c;
    assign split_c = {1'b0, best_ent_reg.len} >=
                     total_reg + (OFFSET_BITS+1)'(HEADER_BYTES + WORD_BYTES);

    logic [OFFSET_BITS-1:0] init_len1, init_off2;
    assign init_len1 = OFFSET_BITS'(size_reg - 24'(2 * HEADER_BYTES));
    assign init_off2 = OFFSET_BITS'(size_reg - 24'(HEADER_BYTES));

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            base_reg      <= '0;
            size_reg      <= 24'd65536;
            count_reg     <= '0;
            fcnt_reg      <= '0;
            initc_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            rd_v_reg      <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_HEAP_BASE)
                begin
                    base_reg <= cfg_data;
                end
                else
                begin
                    size_reg <= cfg_data[23:0];
                end
                state_reg <= S_INIT;
                initc_reg <= '0;
            end
            else
            begin
                unique case (state_reg)
                    S_INIT:
                    begin
                        if (size_reg < 24'(2 * HEADER_BYTES))
                        begin
                            count_reg <= '0;
                            fcnt_reg  <= '0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            initc_reg <= initc_reg + 2'd1;
                            if (initc_reg == 2'd2)
                            begin
                                count_reg <= CW'(3);
                                fcnt_reg  <= size_reg - 24'(2 * HEADER_BYTES);
                                state_reg <= S_IDLE;
                            end
                        end
                    end
                    S_IDLE:
                    begin
                        if (take)
                        begin
                            func_reg  <= req.func;
                            total_reg <= total_calc[OFFSET_BITS:0];
                            rel_reg   <= {1'b0, req.address} - {1'b0, base_reg};
                            idx_reg   <= '0;
                            found_reg <= 1'b0;
                            rd_v_reg  <= 1'b0;
                            ra_reg    <= '0;
                            if (req.func == FUNC_ALLOC && req.request_size == '0)
                            begin
                                st_reg        <= ST_ZERO;
                                rsp_valid_reg <= 1'b1;
                            end
                            else if (req.func == FUNC_ALLOC &&
                                     total_calc[OFFSET_BITS+1])
                            begin
                                st_reg        <= ST_NO_FIT;
                                rsp_valid_reg <= 1'b1;
                            end
                            else if (req.func == FUNC_FREE &&
                                     (req.address < base_reg ||
                                      {1'b0, req.address} - {1'b0, base_reg} >=
                                      33'(size_reg)))
                            begin
                                st_reg        <= ST_BAD_ADDR;
                                rsp_valid_reg <= 1'b1;
                            end
                            else
                            begin
                                state_reg <= S_SCAN;
                            end
                        end
                    end
                    S_SCAN:
                    begin
                        // issue reads idx, evaluate the one from last cycle
                        rd_v_reg <= (idx_reg < count_reg);
                        if (idx_reg < count_reg)
                        begin
                            idx_reg <= idx_reg + CW'(1);
                        end
                        if (rd_v_reg)
                        begin
                            if (func_reg == FUNC_ALLOC)
                            begin
                                if (fit && better)
                                begin
                                    found_reg    <= 1'b1;
                                    best_reg     <= IW'(idx_reg - CW'(1));
                                    best_ent_reg <= rdata;
                                end
                            end
                            else if (hit_c)
                            begin
                                best_reg     <= IW'(idx_reg - CW'(1));
                                best_ent_reg <= rdata;
                                hold_reg     <= rdata;
                                found_reg    <= 1'b1;
                                rd_v_reg     <= 1'b0;
                                state_reg    <= S_DEC;
                            end
                        end
                        if (!(idx_reg < count_reg) && !(rd_v_reg && func_reg == FUNC_FREE
                                                         && hit_c))
                        begin
                            state_reg <= S_DEC;
                        end
                    end
                    S_DEC:
                    begin
                        if (!found_reg)
                        begin
                            st_reg        <= (func_reg == FUNC_ALLOC) ? ST_NO_FIT
                                                                      : ST_BAD_ADDR;
                            rsp_valid_reg <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                        else if (func_reg == FUNC_ALLOC)
                        begin
                            if (split_c)
                            begin
                                if (count_reg >= CW'(MAX_BLOCKS))
                                begin
                                    st_reg        <= ST_NO_FIT;
                                    rsp_valid_reg <= 1'b1;
                                    state_reg     <= S_IDLE;
                                end
                                else
                                begin
                                    // shift entries [best+1, count) up by one
                                    up_reg     <= 1'b1;
                                    mv_reg     <= count_reg;
                                    mv_end_reg <= CW'(best_reg) + CW'(1);
                                    state_reg  <= S_MVRD;
                                end
                            end
                            else
                            begin
                                fcnt_reg  <= fcnt_reg - 24'(best_ent_reg.len);
                                state_reg <= S_DONE;
                            end
                        end
                        else
                        begin
                            // free: read the next entry
                            fcnt_reg      <= fcnt_reg + 24'(best_ent_reg.len);
                            hold_reg.free <= 1'b1;
                            prev_free_reg <= 1'b0;
                            state_reg     <= S_NBRD;
                        end
                    end
                    S_NBRD:
                    begin
                        // read issued for next (best+1) this cycle
                        state_reg <= S_NBCHK;
                    end
                    S_NBCHK:
                    begin
                        gap_reg <= 2'd0;
                        if (CW'(best_reg) + CW'(1) < count_reg && rdata.free)
                        begin
                            hold_reg.len <= hold_reg.len + rdata.len;
                            gap_reg      <= 2'd1;
                        end
                        if (best_reg != '0)
                        begin
                            state_reg <= S_PVCHK;
                        end
                        else
                        begin
                            prev_free_reg <= 1'b0;
                            state_reg     <= S_SPLIT;
                        end
                    end
                    S_PVCHK:
                    begin
                        // read of prev issued in S_NBCHK
                        prev_reg      <= rdata;
                        prev_free_reg <= rdata.free;
                        state_reg     <= S_SPLIT;
                    end
                    S_SPLIT:
                    begin
                        if (func_reg == FUNC_ALLOC)
                        begin
                            fcnt_reg  <= fcnt_reg - 24'(total_reg);
                            count_reg <= count_reg + CW'(1);
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            // merged entry written this cycle; then compact
                            up_reg     <= 1'b0;
                            mv_end_reg <= count_reg;
                            if (prev_free_reg)
                            begin
                                gap_reg <= gap_reg + 2'd1;
                                mv_reg  <= CW'(best_reg) + CW'(1) + CW'(gap_reg);
                            end
                            else
                            begin
                                mv_reg <= CW'(best_reg) + CW'(1) + CW'(gap_reg);
                            end
                            state_reg <= S_MVRD;
                        end
                    end
                    S_MVRD:
                    begin
                        if (up_reg)
                        begin
                            if (mv_reg == mv_end_reg)
                            begin
                                state_reg <= S_SPLIT;
                            end
                            else
                            begin
                                state_reg <= S_MVWR;
                            end
                        end
                        else
                        begin
                            if (mv_reg >= mv_end_reg || gap_reg == 2'd0)
                            begin
                                count_reg <= count_reg - CW'(gap_reg);
                                st_reg        <= ST_OK;
                                rsp_valid_reg <= 1'b1;
                                state_reg     <= S_IDLE;
                            end
                            else
                            begin
                                state_reg <= S_MVWR;
                            end
                        end
                    end
                    S_MVWR:
                    begin
                        mv_reg    <= up_reg ? mv_reg - CW'(1) : mv_reg + CW'(1);
                        state_reg <= S_MVRD;
                    end
                    S_DONE:
                    begin
                        st_reg        <= ST_OK;
                        ra_reg        <= base_reg + 32'(best_ent_reg.off) +
                                         32'(HEADER_BYTES);
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    default:
                    begin
                        state_reg <= S_IDLE;
                    end
                endcase
            end
        end
    end

    // RAM address and write data
    always_comb
    begin
        we    = 1'b0;
        waddr = '0;
        wdata = '0;
        raddr = IW'(idx_reg);
        unique case (state_reg)
            S_INIT:
            begin
                we    = !cfg_we && (size_reg >= 24'(2 * HEADER_BYTES));
                waddr = IW'(initc_reg);
                unique case (initc_reg)
                    2'd0:    wdata = '{off: '0, len: OFFSET_BITS'(HEADER_BYTES),
                                       free: 1'b0};
                    2'd1:    wdata = '{off: OFFSET_BITS'(HEADER_BYTES), len: init_len1,
                                       free: 1'b1};
                    default: wdata = '{off: init_off2, len: OFFSET_BITS'(HEADER_BYTES),
                                       free: 1'b0};
                endcase
            end
            S_DEC:
            begin
                raddr = best_reg + IW'(1);
                if (func_reg == FUNC_ALLOC && !split_c && found_reg)
                begin
                    we    = 1'b1;
                    waddr = best_reg;
                    wdata = '{off: best_ent_reg.off, len: best_ent_reg.len, free: 1'b0};
                end
            end
            S_NBRD:
            begin
                raddr = best_reg + IW'(1);
            end
            S_NBCHK:
            begin
                raddr = best_reg - IW'(1);
            end
            S_SPLIT:
            begin
                we = 1'b1;
                if (func_reg == FUNC_ALLOC)
                begin
                    waddr = best_reg;
                    wdata = '{off: best_ent_reg.off, len: total_reg[OFFSET_BITS-1:0],
                              free: 1'b0};
                end
                else if (prev_free_reg)
                begin
                    waddr = best_reg - IW'(1);
                    wdata = '{off: prev_reg.off, len: prev_reg.len + hold_reg.len,
                              free: 1'b1};
                end
                else
                begin
                    waddr = best_reg;
                    wdata = hold_reg;
                end
            end
            S_MVRD:
            begin
                if (up_reg)
                begin
                    raddr = IW'(mv_reg - CW'(1));
                    if (mv_reg == mv_end_reg)
                    begin
                        // new free tail of the split block
                        we    = 1'b1;
                        waddr = IW'(mv_reg);
                        wdata = '{off: best_ent_reg.off + total_reg[OFFSET_BITS-1:0],
                                  len: best_ent_reg.len - total_reg[OFFSET_BITS-1:0],
                                  free: 1'b1};
                    end
                end
                else
                begin
                    raddr = IW'(mv_reg);
                end
            end
            S_MVWR:
            begin
                we    = 1'b1;
                wdata = rdata;
                waddr = up_reg ? IW'(mv_reg) : IW'(mv_reg - CW'(gap_reg));
            end
            default:
            begin
            end
        endcase
    end

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_BLOCKS))
        else $error("table count exceeds capacity");
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> state_reg == S_IDLE)
        else $error("request taken while busy");
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(st_reg))
        else $error("response dropped before taken");
    a_alloc_addr: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) && st_reg != ST_OK |-> ra_reg == '0)
        else $error("failed operation returns an address");
endmodule

@@ test/tb_best_fit_heap_allocator.sv @@
// Self-checking testbench for the best-fit heap allocator.
`timescale 1ns / 1ps
module tb_best_fit_heap_allocator;
    import bfha_pkg::*;

    localparam int MAX_BLK  = 64;
    localparam int HDR      = 16;
    localparam int WORD     = 8;
    localparam int DRAIN_CY = 3 * MAX_BLK + 20;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] result_address;
        logic [23:0] free_space;
    } heap_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_data;

    bfha_req_if req ();
    bfha_rsp_if rsp ();

    best_fit_heap_allocator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req.sink),
        .rsp       (rsp.source)
    );

    // Predictor copy of the block table
    logic [31:0] heap_base;
    logic [23:0] heap_size;
    logic [23:0] blk_off [MAX_BLK+1];
    logic [23:0] blk_len [MAX_BLK+1];
    logic        blk_free [MAX_BLK+1];
    int          blk_cnt;
    logic [23:0] free_bytes;

    heap_result_t expected_results [$];
    logic [31:0]  live_ptrs [$];
    int           err_cnt;
    int           hold_cycles;
    int           sink_idle_pct;
    int           src_idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #400ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic void rebuild_table();
        blk_cnt    = 0;
        free_bytes = '0;
        if (heap_size < 2 * HDR)
            return;
        blk_off[0] = '0;           blk_len[0] = 24'(HDR);  blk_free[0] = 1'b0;
        blk_off[1] = 24'(HDR);     blk_len[1] = 24'(heap_size - 2 * HDR);
        blk_free[1] = 1'b1;
        blk_off[2] = 24'(heap_size - HDR); blk_len[2] = 24'(HDR); blk_free[2] = 1'b0;
        blk_cnt    = 3;
        free_bytes = 24'(heap_size - 2 * HDR);
    endfunction

    function automatic void drop_entry(int idx);
        for (int k = idx; k + 1 < blk_cnt; k++)
        begin
            blk_off[k]  = blk_off[k+1];
            blk_len[k]  = blk_len[k+1];
            blk_free[k] = blk_free[k+1];
        end
        blk_cnt--;
    endfunction

    function automatic heap_result_t predict_alloc(logic [23:0] req_bytes);
        heap_result_t r;
        longint       total;
        int           best;
        r      = '0;
        best   = -1;
        total  = ((longint'(req_bytes) + WORD - 1) / WORD) * WORD + HDR;
        if (req_bytes == 0)
            r.status = ST_ZERO;
        else
        begin
            for (int i = 0; i < blk_cnt; i++)
                if (blk_free[i] && blk_len[i] >= total &&
                    (best < 0 || blk_len[i] < blk_len[best]))
                    best = i;
            r.status = ST_NO_FIT;
            if (best >= 0)
            begin
                if (blk_len[best] >= total + HDR + WORD)
                begin
                    if (blk_cnt < MAX_BLK)
                    begin
                        for (int k = blk_cnt; k > best + 1; k--)
                        begin
                            blk_off[k]  = blk_off[k-1];
                            blk_len[k]  = blk_len[k-1];
                            blk_free[k] = blk_free[k-1];
                        end
                        blk_off[best+1]  = blk_off[best] + 24'(total);
                        blk_len[best+1]  = blk_len[best] - 24'(total);
                        blk_free[best+1] = 1'b1;
                        blk_cnt++;
                        blk_len[best] = 24'(total);
                        free_bytes    = free_bytes - 24'(total);
                        r.status      = ST_OK;
                    end
                end
                else
                begin
                    free_bytes = free_bytes - blk_len[best];
                    r.status   = ST_OK;
                end
                if (r.status == ST_OK)
                begin
                    blk_free[best]   = 1'b0;
                    r.result_address = heap_base + 32'(blk_off[best]) + HDR;
                end
            end
        end
        r.free_space = free_bytes;
        return r;
    endfunction

    function automatic heap_result_t predict_free(logic [31:0] ptr);
        heap_result_t r;
        longint       rel;
        int           hit;
        r        = '0;
        hit      = -1;
        r.status = ST_BAD_ADDR;
        if (ptr >= heap_base)
        begin
            rel = longint'(ptr) - longint'(heap_base);
            if (rel < heap_size)
                for (int i = 0; i < blk_cnt && hit < 0; i++)
                    if (!blk_free[i] && rel >= longint'(blk_off[i]) + HDR &&
                        rel < longint'(blk_off[i]) + longint'(blk_len[i]))
                        hit = i;
        end
        if (hit >= 0)
        begin
            r.status      = ST_OK;
            blk_free[hit] = 1'b1;
            free_bytes    = free_bytes + blk_len[hit];
            if (hit + 1 < blk_cnt && blk_free[hit+1])
            begin
                blk_len[hit] = blk_len[hit] + blk_len[hit+1];
                drop_entry(hit + 1);
            end
            if (hit > 0 && blk_free[hit-1])
            begin
                blk_len[hit-1] = blk_len[hit-1] + blk_len[hit];
                drop_entry(hit);
            end
        end
        r.free_space = free_bytes;
        return r;
    endfunction

    // Send one request beat and queue its prediction
    task automatic send_op(logic op, logic [23:0] req_bytes, logic [31:0] ptr);
        heap_result_t r;
        while (($urandom_range(99) < src_idle_pct))
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid        <= 1'b1;
        req.func         <= op;
        req.request_size <= req_bytes;
        req.address      <= ptr;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        if (op == FUNC_ALLOC)
        begin
            r = predict_alloc(req_bytes);
            if (r.status == ST_OK)
                live_ptrs.push_back(r.result_address);
        end
        else
            r = predict_free(ptr);
        expected_results.push_back(r);
    endtask

    task automatic wait_idle();
        req.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CY) @(posedge clk);
    endtask

    task automatic write_cfg(logic idx, logic [31:0] val);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_HEAP_BASE)
            heap_base = val;
        else
            heap_size = val[23:0];
        rebuild_table();
        live_ptrs.delete();
        repeat (5) @(posedge clk);
    endtask

    function automatic logic [23:0] rand_size();
        case ($urandom_range(9))
            0:       return 24'($urandom);
            1:       return 24'($urandom_range(8, 1));
            2:       return 24'hFFFFFF;
            default: return 24'($urandom_range(600, 1));
        endcase
    endfunction

    // Allocs and frees; frees mostly of live pointers, some offset or junk
    task automatic rand_ops(int n);
        int idx;
        logic [31:0] p;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 52 || live_ptrs.size() == 0)
                send_op(FUNC_ALLOC, ($urandom_range(30) == 0) ? 24'd0 : rand_size(), $urandom);
            else
            begin
                idx = $urandom_range(live_ptrs.size() - 1);
                p   = live_ptrs[idx];
                case ($urandom_range(9))
                    0:       p = $urandom;
                    1:       p = p - $urandom_range(16, 1);
                    2:       p = p + $urandom_range(64);
                    default: live_ptrs.delete(idx);
                endcase
                send_op(FUNC_FREE, 24'($urandom), p);
            end
        end
    endtask

    task automatic test_directed();
        send_op(FUNC_ALLOC, 24'd0, 32'hFFFFFFFF);
        send_op(FUNC_ALLOC, 24'd1, 32'h0);
        send_op(FUNC_ALLOC, 24'd8, 32'h0);
        send_op(FUNC_ALLOC, 24'd9, 32'h0);
        send_op(FUNC_ALLOC, 24'hFFFFFF, 32'h0);
        send_op(FUNC_ALLOC, 24'd65504, 32'h0);
        send_op(FUNC_FREE, 24'hFFFFFF, 32'h0);
        send_op(FUNC_FREE, 24'h0, 32'd16);
        send_op(FUNC_FREE, 24'h0, 32'd32);
        send_op(FUNC_FREE, 24'h0, 32'd48);
        send_op(FUNC_FREE, 24'h0, 32'd40);
        send_op(FUNC_FREE, 24'h0, 32'd70000);
        send_op(FUNC_FREE, 24'h0, 32'hFFFFFFFF);
        send_op(FUNC_ALLOC, 24'd65480, 32'h0);
        send_op(FUNC_ALLOC, 24'd8, 32'h0);
    endtask

    // Fill the table with small blocks until splits fail
    task automatic test_table_full();
        for (int i = 0; i < 70; i++)
            send_op(FUNC_ALLOC, 24'($urandom_range(16, 1)), $urandom);
        rand_ops(40);
    endtask

    task automatic test_tiny_heaps();
        write_cfg(CFG_HEAP_SIZE, 32'd31);
        send_op(FUNC_ALLOC, 24'd1, 32'h0);
        send_op(FUNC_FREE, 24'h0, 32'd16);
        write_cfg(CFG_HEAP_SIZE, 32'd32);
        send_op(FUNC_ALLOC, 24'd1, 32'h0);
        send_op(FUNC_FREE, 24'h0, 32'd16);
        write_cfg(CFG_HEAP_SIZE, 32'd64);
        rand_ops(20);
    endtask

    task automatic test_base_wrap();
        write_cfg(CFG_HEAP_BASE, 32'hFFFFFF00);
        write_cfg(CFG_HEAP_SIZE, 32'h00FFFFFF);
        send_op(FUNC_FREE, 24'h0, 32'h0000_0010);
        rand_ops(150);
        write_cfg(CFG_HEAP_BASE, 32'h0);
        write_cfg(CFG_HEAP_SIZE, 32'd20);
        send_op(FUNC_ALLOC, 24'd4, 32'h0);
    endtask

    // Long receiver hold-off while requests keep coming
    task automatic test_backpressure();
        write_cfg(CFG_HEAP_BASE, $urandom);
        write_cfg(CFG_HEAP_SIZE, 32'd4096);
        hold_cycles = 400;
        rand_ops(30);
    endtask

    task automatic test_random();
        write_cfg(CFG_HEAP_SIZE, 32'd8192);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        rand_ops(300);
        src_idle_pct  = 13;
        sink_idle_pct = 13;
        rand_ops(400);
        write_cfg(CFG_HEAP_BASE, $urandom);
        write_cfg(CFG_HEAP_SIZE, $urandom_range(20000, 1024));
        rand_ops(400);
        write_cfg(CFG_HEAP_SIZE, 32'd1024);
        rand_ops(300);
    endtask

    // Response ready with random stalls and the pressure hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            rsp.ready   <= 1'b0;
        end
        else
            rsp.ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Compare each response beat with the oldest prediction
    always @(posedge clk)
    begin
        heap_result_t exp_r;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected response beat");
                err_cnt++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (rsp.status !== exp_r.status)
                begin
                    $error("status exp %0d got %0d", exp_r.status, rsp.status);
                    err_cnt++;
                end
                if (rsp.result_address !== exp_r.result_address)
                begin
                    $error("result_address exp %h got %h", exp_r.result_address,
                           rsp.result_address);
                    err_cnt++;
                end
                if (rsp.free_space !== exp_r.free_space)
                begin
                    $error("free_space exp %0d got %0d", exp_r.free_space,
                           rsp.free_space);
                    err_cnt++;
                end
            end
        end
    end

    initial
    begin
        err_cnt          = 0;
        hold_cycles      = 0;
        sink_idle_pct    = 13;
        src_idle_pct     = 13;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = CFG_HEAP_BASE;
        cfg_data         = '0;
        req.valid        = 1'b0;
        req.func         = FUNC_ALLOC;
        req.request_size = '0;
        req.address      = '0;
        heap_base        = 32'h0;
        heap_size        = 24'd65536;
        rebuild_table();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (5) @(posedge clk);

        test_directed();
        test_table_full();
        test_tiny_heaps();
        test_base_wrap();
        test_backpressure();
        test_random();

        wait_idle();
        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

@@ best_fit_heap_allocator.f @@
hw/rtl/bfha_pkg.sv
hw/rtl/bfha_req_if.sv
hw/rtl/bfha_ram.sv
hw/rtl/best_fit_heap_allocator.sv
test/tb_best_fit_heap_allocator.sv
